/* rtl/mh64_pkg.sv */
// MurmurHash64A stream hasher: shared constants, codes and control types.
// Used by the interfaces, the controller, the datapath and the top level.
package mh64_pkg;

	localparam int DATA_W      = 64;
	localparam int COUNT_W     = 4;
	localparam int LEN_W       = 16;
	localparam int HALF_W      = DATA_W / 2;
	localparam int LENGTH_BITS = 16;

	localparam logic [LEN_W-1:0] LEN_MASK = (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}}
		: LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

	localparam logic [DATA_W-1:0] MUR_SEED  = 64'h0000_0000_c70f_6907;
	localparam logic [DATA_W-1:0] MUR_MUL   = 64'hc6a4_a793_5bd1_e995;
	localparam int                MUR_SHIFT = 47;

	// operand select for the shared multiplier
	localparam logic [2:0] X_LEN   = 3'd0;
	localparam logic [2:0] X_WORD  = 3'd1;
	localparam logic [2:0] X_KMIX  = 3'd2;
	localparam logic [2:0] X_HXK   = 3'd3;
	localparam logic [2:0] X_HTAIL = 3'd4;
	localparam logic [2:0] X_HFIN  = 3'd5;

	// steps of one 64-bit multiply
	localparam logic [1:0] STEP_LOAD  = 2'd0;
	localparam logic [1:0] STEP_LO    = 2'd1;
	localparam logic [1:0] STEP_CROSS = 2'd2;
	localparam logic [1:0] STEP_HI    = 2'd3;

	typedef struct packed {
		logic       capture;
		logic       x_load;
		logic [2:0] x_sel;
		logic       mul_en;
		logic [1:0] step;
		logic       h_load;
		logic       h_seed;
		logic       out_load;
	} mh64_cmd_t;

	typedef struct packed {
		logic count_full;
		logic count_zero;
		logic last;
	} mh64_status_t;

endpackage

/* rtl/mh64_key_if.sv */
// Input channel of the hasher: one key word per item with valid/ready.
// Depends on mh64_pkg for field widths.
interface mh64_key_if import mh64_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   data_word;
	logic [COUNT_W-1:0]  byte_count;
	logic                is_last;
	logic [LEN_W-1:0]    total_length;

	modport source (output valid, data_word, byte_count, is_last, total_length, input ready);
	modport sink   (input valid, data_word, byte_count, is_last, total_length, output ready);
endinterface

/* rtl/mh64_hash_if.sv */
// Output channel of the hasher: one finalized hash per item with valid/ready.
// Depends on mh64_pkg for the hash width.
interface mh64_hash_if import mh64_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink   (input valid, hash_value, output ready);
endinterface

/* rtl/mh64_dp.sv */
// Datapath of the hasher: captured word, running hash, shared 32x32 multiplier.
// Driven by mh64_ctrl through mh64_cmd_t; depends on mh64_pkg.
module mh64_dp import mh64_pkg::*; (
	input  logic               clk,
	input  mh64_cmd_t          cmd,
	input  logic [DATA_W-1:0]  data_word,
	input  logic [COUNT_W-1:0] byte_count,
	input  logic               is_last,
	input  logic [LEN_W-1:0]   total_length,
	output mh64_status_t       status,
	output logic [DATA_W-1:0]  hash_value
);

	logic [DATA_W-1:0]  word_q;
	logic [COUNT_W-1:0] count_q;
	logic               last_q;
	logic [LEN_W-1:0]   len_q;
	logic [DATA_W-1:0]  x_q;
	logic [DATA_W-1:0]  p_q;
	logic [DATA_W-1:0]  h_q;
	logic [DATA_W-1:0]  hash_q;

	logic [DATA_W-1:0]  tail_mask;
	logic [DATA_W-1:0]  x_next;
	logic [HALF_W-1:0]  mul_a;
	logic [HALF_W-1:0]  mul_b;
	logic [DATA_W-1:0]  prod;
	logic [DATA_W-1:0]  p_next;
	logic [COUNT_W-1:0] count_sel;

	always_comb begin
		count_sel         = cmd.capture ? byte_count : count_q;
		status.count_full = count_sel[COUNT_W-1];
		status.count_zero = (count_sel == '0);
		status.last       = cmd.capture ? is_last : last_q;
	end

	always_comb begin
		for (int i = 0; i < DATA_W / 8; i++) begin
			tail_mask[i*8 +: 8] = (COUNT_W'(i) < count_q) ? 8'hff : 8'h00;
		end
	end

	always_comb begin
		unique case (cmd.x_sel)
			X_LEN:   x_next = DATA_W'(len_q & LEN_MASK);
			X_WORD:  x_next = word_q;
			X_KMIX:  x_next = p_q ^ (p_q >> MUR_SHIFT);
			X_HXK:   x_next = h_q ^ p_q;
			X_HTAIL: x_next = h_q ^ (word_q & tail_mask);
			X_HFIN:  x_next = h_q ^ (h_q >> MUR_SHIFT);
			default: x_next = word_q;
		endcase
	end

	assign mul_a  = (cmd.step == STEP_HI) ? x_q[DATA_W-1:HALF_W] : x_q[HALF_W-1:0];
	assign mul_b  = (cmd.step == STEP_CROSS) ? MUR_MUL[DATA_W-1:HALF_W] : MUR_MUL[HALF_W-1:0];
	assign prod   = DATA_W'(mul_a) * DATA_W'(mul_b);
	assign p_next = (cmd.step == STEP_LO) ? prod : p_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			word_q  <= data_word;
			count_q <= byte_count;
			last_q  <= is_last;
			len_q   <= total_length;
		end
		if (cmd.x_load) begin
			x_q <= x_next;
		end
		if (cmd.mul_en) begin
			p_q <= p_next;
		end
		if (cmd.h_load) begin
			h_q <= cmd.h_seed ? (MUR_SEED ^ p_next) : p_next;
		end
		if (cmd.out_load) begin
			hash_q <= p_next ^ (p_next >> MUR_SHIFT);
		end
	end

	assign hash_value = hash_q;

endmodule

/* rtl/mh64_ctrl.sv */
// Controller of the hasher: sequences seed, word mix, tail and finalization.
// Drives mh64_dp through mh64_cmd_t; depends on mh64_pkg.
module mh64_ctrl import mh64_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         key_valid,
	output logic         key_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  mh64_status_t status,
	output mh64_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEED = 3'd1;
	localparam logic [2:0] ST_K1   = 3'd2;
	localparam logic [2:0] ST_K2   = 3'd3;
	localparam logic [2:0] ST_MIX  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] step_q, step_d;
	logic       inside_q, inside_d;
	logic       out_valid_q;
	logic       out_free;
	logic       busy;
	logic       last_step;
	logic       advance;
	logic [2:0] pick;

	assign out_free  = !out_valid_q || out_ready;
	assign busy      = (state_q != ST_IDLE);
	assign last_step = (step_q == STEP_HI);
	assign advance   = busy && (!(last_step && state_q == ST_FIN) || out_free);
	assign key_ready = !busy;
	assign out_valid = out_valid_q;

	always_comb begin
		priority if (status.count_full) pick = ST_K1;
		else if (!status.count_zero)    pick = ST_MIX;
		else if (status.last)           pick = ST_FIN;
		else                            pick = ST_IDLE;
	end

	always_comb begin
		cmd          = '0;
		cmd.step     = step_q;
		cmd.x_load   = busy && (step_q == STEP_LOAD);
		cmd.mul_en   = advance && (step_q != STEP_LOAD);
		state_d      = state_q;
		step_d       = step_q;
		inside_d     = inside_q;

		unique case (state_q)
			ST_SEED: cmd.x_sel = X_LEN;
			ST_K1:   cmd.x_sel = X_WORD;
			ST_K2:   cmd.x_sel = X_KMIX;
			ST_MIX:  cmd.x_sel = status.count_full ? X_HXK : X_HTAIL;
			ST_FIN:  cmd.x_sel = X_HFIN;
			default: cmd.x_sel = X_WORD;
		endcase

		if (!busy && key_valid) begin
			cmd.capture = 1'b1;
			if (!inside_q) begin
				state_d = ST_SEED;
			end else begin
				state_d = pick;
			end
			if (inside_q && pick == ST_IDLE) begin
				inside_d = 1'b1;
			end
		end

		if (advance) begin
			step_d = step_q + 2'd1;
		end

		if (advance && last_step) begin
			unique case (state_q)
				ST_SEED: begin
					cmd.h_load = 1'b1;
					cmd.h_seed = 1'b1;
					state_d    = pick;
					if (pick == ST_IDLE) begin
						inside_d = 1'b1;
					end
				end
				ST_K1: state_d = ST_K2;
				ST_K2: state_d = ST_MIX;
				ST_MIX: begin
					cmd.h_load = 1'b1;
					if (status.last) begin
						state_d = ST_FIN;
					end else begin
						state_d  = ST_IDLE;
						inside_d = 1'b1;
					end
				end
				ST_FIN: begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
					inside_d     = 1'b0;
				end
				default: state_d = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_LOAD;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			step_q   <= step_d;
			inside_q <= inside_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/murmur64a_stream_hash.sv */
// MurmurHash64A stream hasher, top level: controller, datapath, item channels.
// Depends on mh64_pkg, mh64_key_if, mh64_hash_if, mh64_ctrl and mh64_dp.
//
// Takes a key as little-endian 64-bit words and returns its MurmurHash64A
// (fixed seed 0xc70f6907) after the word marked last. All multiplies run on
// one shared 32x32 multiplier; each 64-bit multiply is an operand load plus
// three partial products. An item is taken at the port and then needs one
// multiply for the length seed on a key's first word, three for a full word,
// one for a tail of 1 to 7 bytes, none for an empty word and one for the
// finalization on the last word. The finished hash waits in an output
// register while the next key is taken; only a second finalization stalls on
// a result not yet taken.
module murmur64a_stream_hash import mh64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mh64_key_if.sink    key,
	mh64_hash_if.source digest
);

	mh64_cmd_t    cmd;
	mh64_status_t status;

	mh64_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key.valid),
		.key_ready (key.ready),
		.out_valid (digest.valid),
		.out_ready (digest.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mh64_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.data_word    (key.data_word),
		.byte_count   (key.byte_count),
		.is_last      (key.is_last),
		.total_length (key.total_length),
		.status       (status),
		.hash_value   (digest.hash_value)
	);

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.x_load, cmd.h_load, cmd.out_load}))
		else $error("datapath loads overlap");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!digest.valid || digest.ready))
		else $error("hash overwritten before taken");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest.valid) |-> $past(cmd.out_load))
		else $error("result without finalization");

	a_no_capture_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !cmd.mul_en && !cmd.x_load)
		else $error("item taken while multiplying");

endmodule
